@@ sv/svsg_pkg.sv @@
// Shared types, constants and width helpers for the voxel subdivision seed generator.
`timescale 1ns / 1ps

package svsg_pkg;

    localparam int COORD_W    = 32;
    localparam int SIZE_W     = 31;
    localparam int FRAC_W     = 16;
    localparam int SUB_W      = 14;
    localparam int NUM_W      = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int LEVEL_W    = 2;
    localparam int QUEUE_DEPTH = 2;

    // seed_t plus seed number, padded to whole bytes
    localparam int OUT_RAW_W  = 3 * COORD_W + 3 * SUB_W + NUM_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LEVEL = 3'd0,
        CFG_X_MIN = 3'd1,
        CFG_X_MAX = 3'd2,
        CFG_Y_MIN = 3'd3,
        CFG_Y_MAX = 3'd4,
        CFG_Z_MIN = 3'd5,
        CFG_Z_MAX = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] z_max;
        logic signed [COORD_W-1:0] z_min;
        logic signed [COORD_W-1:0] y_max;
        logic signed [COORD_W-1:0] y_min;
        logic signed [COORD_W-1:0] x_max;
        logic signed [COORD_W-1:0] x_min;
    } bounds_t;

    // last field (seed_x) in the lowest bits
    typedef struct packed {
        logic [SUB_W-1:0]          sub_z;
        logic [SUB_W-1:0]          sub_y;
        logic [SUB_W-1:0]          sub_x;
        logic signed [COORD_W-1:0] seed_z;
        logic signed [COORD_W-1:0] seed_y;
        logic signed [COORD_W-1:0] seed_x;
    } seed_t;

    typedef struct packed {
        logic walk_active;
        logic cand_valid;
        logic pend_valid;
        logic pend_closed;
    } back_stat_t;

    function automatic int lvl_w(input int max_ref);
        return (max_ref > 1) ? $clog2(max_ref + 1) : 1;
    endfunction

    function automatic int idx_w(input int max_ref);
        return (max_ref > 0) ? max_ref : 1;
    endfunction

    // level, three steps, three bases (one guard bit), three cell indices
    function automatic int item_w(input int cib, input int max_ref);
        return lvl_w(max_ref) + 3 * SIZE_W + 3 * (COORD_W + 1) + 3 * cib;
    endfunction

    function automatic int in_data_w(input int cib);
        return ((3 * cib + 3 * COORD_W + 3 * SIZE_W + FRAC_W + 7) / 8) * 8;
    endfunction

endpackage

@@ sv/voxel_subdivision_seed_generator.sv @@
// Voxel subdivision seed generator: top level with configuration registers.
//
// Input stream (s_*): one beat per grid cell. Output stream (m_*): one beat per
// seed, tlast set on the last seed emitted for a cell. Cells with a zero
// fraction are taken and dropped. Each other cell is split into 2^r sub-cells
// per axis; the walker visits one sub-cell per cycle while the output does not
// stall, x fastest, so a cell has 1, 8 or 64 sub-cells at r = 0, 1, 2.
// The front end takes a cell beat in any cycle in which the two-entry cell
// queue has room, so cells stream in back to back while earlier ones are walked.
// With an idle back end, a taken cell beat passes the queue, walker load,
// candidate stage, pending stage and output register before m_tvalid rises.
// A seed is held in the one-seed pending stage until the next seed of
// the same cell is found inside the box or the walk of the cell ends, which
// settles tlast. Throughput is bounded by the walker at one sub-cell a cycle.
// When m_tready is low the output register holds, the walker stops and the
// queue fills; s_tready drops once it is full.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once;
// the user must make them while the block is idle; the block does not check.
// Reset clears queue, pipeline, seed counter and config (empty box, no seeds).
`timescale 1ns / 1ps

module voxel_subdivision_seed_generator #(
    parameter int MAX_REFINEMENT  = 2,
    parameter int CELL_INDEX_BITS = 12,
    localparam int IN_DATA_W = svsg_pkg::in_data_w(CELL_INDEX_BITS)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cell_ix, cell_iy, cell_iz, center_x, center_y, center_z,
    // size_x, size_y, size_z, fraction, zero pad
    input  logic [IN_DATA_W-1:0]                s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // seed_x, seed_y, seed_z, sub_x, sub_y, sub_z, seed_number, zero pad
    output logic [svsg_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [svsg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [svsg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int ITEM_W = svsg_pkg::item_w(CELL_INDEX_BITS, MAX_REFINEMENT);
    localparam int NUM_LO = svsg_pkg::OUT_RAW_W - svsg_pkg::NUM_W;
    localparam int NUM_HI = svsg_pkg::OUT_RAW_W - 1;

    logic [svsg_pkg::LEVEL_W-1:0] level_reg, level_next;
    svsg_pkg::bounds_t            bounds_reg, bounds_next;

    logic                 q_push, q_full, q_pop, q_valid;
    logic [ITEM_W-1:0]    q_in, q_out;
    svsg_pkg::back_stat_t stat;

    always_comb
    begin
        level_next  = level_reg;
        bounds_next = bounds_reg;
        if (cfg_we)
        begin
            unique case (svsg_pkg::cfg_index_t'(cfg_addr))
                svsg_pkg::CFG_LEVEL: level_next        = cfg_wdata[svsg_pkg::LEVEL_W-1:0];
                svsg_pkg::CFG_X_MIN: bounds_next.x_min = cfg_wdata;
                svsg_pkg::CFG_X_MAX: bounds_next.x_max = cfg_wdata;
                svsg_pkg::CFG_Y_MIN: bounds_next.y_min = cfg_wdata;
                svsg_pkg::CFG_Y_MAX: bounds_next.y_max = cfg_wdata;
                svsg_pkg::CFG_Z_MIN: bounds_next.z_min = cfg_wdata;
                svsg_pkg::CFG_Z_MAX: bounds_next.z_max = cfg_wdata;
                default:             level_next        = level_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= '0;
            bounds_reg <= '0;
        end
        else
        begin
            level_reg  <= level_next;
            bounds_reg <= bounds_next;
        end
    end

    svsg_front #(
        .CELL_INDEX_BITS (CELL_INDEX_BITS),
        .MAX_REFINEMENT  (MAX_REFINEMENT)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_level  (level_reg),
        .queue_full (q_full),
        .push       (q_push),
        .push_data  (q_in)
    );

    svsg_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (svsg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    svsg_back #(
        .CELL_INDEX_BITS (CELL_INDEX_BITS),
        .MAX_REFINEMENT  (MAX_REFINEMENT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .bounds   (bounds_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .stat     (stat)
    );

`ifndef SYNTHESIS
    // seed numbers run on by one from beat to beat
    a_seed_number_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=>
            (!m_tvalid || (m_tdata[NUM_HI:NUM_LO] == $past(m_tdata[NUM_HI:NUM_LO]) + 1'b1)))
        else $error("seed number did not advance by one");

    // a closed pending seed goes out with tlast as soon as the output is free
    a_closed_seed_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.pend_valid && stat.pend_closed && (!m_tvalid || m_tready)) |=>
            (m_tvalid && m_tlast))
        else $error("last seed of a cell was not flushed with tlast");

    // an idle walker picks up a queued cell at the next edge
    a_queue_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !stat.walk_active) |=> stat.walk_active)
        else $error("queued cell not picked up by an idle walker");
`endif

endmodule

@@ sv/svsg_fifo.sv @@
// Small register queue between the cell classifier and the sub-cell walker.
`timescale 1ns / 1ps

module svsg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/svsg_front.sv @@
// Front end: takes cell beats, drops empty cells, derives sub-cell step and origin.
`timescale 1ns / 1ps

module svsg_front #(
    parameter int CELL_INDEX_BITS = 12,
    parameter int MAX_REFINEMENT  = 2,
    localparam int LVL_W  = svsg_pkg::lvl_w(MAX_REFINEMENT),
    localparam int ITEM_W = svsg_pkg::item_w(CELL_INDEX_BITS, MAX_REFINEMENT),
    localparam int IN_W   = svsg_pkg::in_data_w(CELL_INDEX_BITS)
) (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [IN_W-1:0]                    s_tdata,
    input  logic [svsg_pkg::LEVEL_W-1:0]       cfg_level,
    input  logic                               queue_full,
    output logic                               push,
    output logic [ITEM_W-1:0]                  push_data
);

    localparam int CIB     = CELL_INDEX_BITS;
    localparam int COORD_W = svsg_pkg::COORD_W;
    localparam int SIZE_W  = svsg_pkg::SIZE_W;
    localparam int CTR_LO  = 3 * CIB;
    localparam int SIZE_LO = CTR_LO + 3 * COORD_W;
    localparam int FRAC_LO = SIZE_LO + 3 * SIZE_W;

    typedef struct packed {
        logic [LVL_W-1:0]          level;
        logic [SIZE_W-1:0]         step_z;
        logic [SIZE_W-1:0]         step_y;
        logic [SIZE_W-1:0]         step_x;
        logic signed [COORD_W:0]   base_z;
        logic signed [COORD_W:0]   base_y;
        logic signed [COORD_W:0]   base_x;
        logic [CIB-1:0]            cell_z;
        logic [CIB-1:0]            cell_y;
        logic [CIB-1:0]            cell_x;
    } cell_item_t;

    logic [LVL_W-1:0]          level;
    logic [svsg_pkg::FRAC_W-1:0] fraction;
    logic [COORD_W-1:0]        center [3];
    logic [SIZE_W-1:0]         size_in [3];
    logic [SIZE_W-1:0]         step [3];
    logic [SIZE_W-1:0]         back_off [3];
    logic signed [COORD_W:0]   base [3];
    cell_item_t                item;

    assign level = (int'(cfg_level) > MAX_REFINEMENT) ? LVL_W'(MAX_REFINEMENT)
                                                      : LVL_W'(cfg_level);
    assign fraction = s_tdata[FRAC_LO +: svsg_pkg::FRAC_W];

    // halve the edge once per level and pull the origin back by half the new edge
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            center[a]   = s_tdata[CTR_LO + a * COORD_W +: COORD_W];
            size_in[a]  = s_tdata[SIZE_LO + a * SIZE_W +: SIZE_W];
            step[a]     = size_in[a];
            back_off[a] = '0;
            for (int lv = 0; lv < MAX_REFINEMENT; lv++)
            begin
                if (lv < int'(level))
                begin
                    step[a]     = step[a] >> 1;
                    back_off[a] = back_off[a] + (step[a] >> 1);
                end
            end
            base[a] = $signed({center[a][COORD_W-1], center[a]})
                    - $signed({2'b00, back_off[a]});
        end
    end

    always_comb
    begin
        item.level  = level;
        item.step_x = step[0];
        item.step_y = step[1];
        item.step_z = step[2];
        item.base_x = base[0];
        item.base_y = base[1];
        item.base_z = base[2];
        item.cell_x = s_tdata[0 +: CIB];
        item.cell_y = s_tdata[CIB +: CIB];
        item.cell_z = s_tdata[2 * CIB +: CIB];
    end

    assign s_tready  = !queue_full;
    assign push      = s_tvalid && !queue_full && (fraction != '0);
    assign push_data = item;

endmodule

@@ sv/svsg_back.sv @@
// Back end: walks the sub-cells of each queued cell, filters by the box, flags the last seed.
`timescale 1ns / 1ps

module svsg_back #(
    parameter int CELL_INDEX_BITS = 12,
    parameter int MAX_REFINEMENT  = 2,
    localparam int LVL_W  = svsg_pkg::lvl_w(MAX_REFINEMENT),
    localparam int ITEM_W = svsg_pkg::item_w(CELL_INDEX_BITS, MAX_REFINEMENT)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    input  logic [ITEM_W-1:0]                     q_data,
    output logic                                  q_pop,
    input  svsg_pkg::bounds_t                     bounds,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [svsg_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                  m_tlast,
    output svsg_pkg::back_stat_t                  stat
);

    localparam int CIB     = CELL_INDEX_BITS;
    localparam int COORD_W = svsg_pkg::COORD_W;
    localparam int SIZE_W  = svsg_pkg::SIZE_W;
    localparam int SUB_W   = svsg_pkg::SUB_W;
    localparam int NUM_W   = svsg_pkg::NUM_W;
    localparam int IDX_W   = svsg_pkg::idx_w(MAX_REFINEMENT);
    localparam int PROD_W  = IDX_W + SIZE_W;
    localparam int P_W     = PROD_W + 2;
    localparam int PAD_W   = svsg_pkg::OUT_DATA_W - svsg_pkg::OUT_RAW_W;

    typedef struct packed {
        logic [LVL_W-1:0]          level;
        logic [SIZE_W-1:0]         step_z;
        logic [SIZE_W-1:0]         step_y;
        logic [SIZE_W-1:0]         step_x;
        logic signed [COORD_W:0]   base_z;
        logic signed [COORD_W:0]   base_y;
        logic signed [COORD_W:0]   base_x;
        logic [CIB-1:0]            cell_z;
        logic [CIB-1:0]            cell_y;
        logic [CIB-1:0]            cell_x;
    } cell_item_t;

    function automatic logic signed [P_W-1:0] seed_pos(
        input logic signed [COORD_W:0] base,
        input logic [IDX_W-1:0]        idx,
        input logic [SIZE_W-1:0]       step
    );
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(idx) * PROD_W'(step);
        return $signed({{(P_W - COORD_W - 1){base[COORD_W]}}, base})
             + $signed({2'b00, prod});
    endfunction

    function automatic logic in_range(
        input logic signed [P_W-1:0]     pos,
        input logic signed [COORD_W-1:0] lo,
        input logic signed [COORD_W-1:0] hi
    );
        logic signed [P_W-1:0] lo_x;
        logic signed [P_W-1:0] hi_x;
        lo_x = {{(P_W - COORD_W){lo[COORD_W-1]}}, lo};
        hi_x = {{(P_W - COORD_W){hi[COORD_W-1]}}, hi};
        return (pos >= lo_x) && (pos < hi_x);
    endfunction

    function automatic logic [SUB_W-1:0] sub_pos(
        input logic [CIB-1:0]   cell_idx,
        input logic [LVL_W-1:0] level,
        input logic [IDX_W-1:0] idx
    );
        logic [31:0] t;
        t = (32'(cell_idx) << level) + 32'(idx);
        return t[SUB_W-1:0];
    endfunction

    // walker
    logic                 w_active_reg, w_active_next;
    cell_item_t           w_item_reg, w_item_next;
    logic [IDX_W-1:0]     ix_reg, ix_next, iy_reg, iy_next, iz_reg, iz_next;
    // candidate stage
    logic                 c_valid_reg, c_valid_next;
    logic                 c_inside_reg, c_inside_next;
    logic                 c_end_reg, c_end_next;
    svsg_pkg::seed_t      c_seed_reg, c_seed_next;
    // pending seed, held until the next inside seed or the end of its cell
    logic                 p_valid_reg, p_valid_next;
    logic                 p_closed_reg, p_closed_next;
    svsg_pkg::seed_t      p_seed_reg, p_seed_next;
    // output register
    logic                 o_valid_reg, o_valid_next;
    logic                 o_last_reg, o_last_next;
    svsg_pkg::seed_t      o_seed_reg, o_seed_next;
    logic [NUM_W-1:0]     o_num_reg, o_num_next;
    logic [NUM_W-1:0]     count_reg, count_next;

    logic                 [IDX_W-1:0] lim;
    logic                 last_x, last_y, last_z, w_last;
    logic                 emit, o_free, adv, c_take, load;
    logic signed [P_W-1:0] pos_x, pos_y, pos_z;
    svsg_pkg::seed_t      cand;
    logic                 cand_inside;

    assign lim    = IDX_W'((32'd1 << w_item_reg.level) - 32'd1);
    assign last_x = (ix_reg == lim);
    assign last_y = (iy_reg == lim);
    assign last_z = (iz_reg == lim);
    assign w_last = last_x && last_y && last_z;

    assign emit   = p_valid_reg && (p_closed_reg || (c_valid_reg && c_inside_reg));
    assign o_free = !o_valid_reg || m_tready;
    assign adv    = !emit || o_free;
    assign c_take = w_active_reg && (!c_valid_reg || adv);
    assign load   = q_valid && (!w_active_reg || (c_take && w_last));
    assign q_pop  = load;

    always_comb
    begin
        pos_x = seed_pos(w_item_reg.base_x, ix_reg, w_item_reg.step_x);
        pos_y = seed_pos(w_item_reg.base_y, iy_reg, w_item_reg.step_y);
        pos_z = seed_pos(w_item_reg.base_z, iz_reg, w_item_reg.step_z);
        cand_inside = in_range(pos_x, bounds.x_min, bounds.x_max)
                   && in_range(pos_y, bounds.y_min, bounds.y_max)
                   && in_range(pos_z, bounds.z_min, bounds.z_max);
        cand.seed_x = pos_x[COORD_W-1:0];
        cand.seed_y = pos_y[COORD_W-1:0];
        cand.seed_z = pos_z[COORD_W-1:0];
        cand.sub_x  = sub_pos(w_item_reg.cell_x, w_item_reg.level, ix_reg);
        cand.sub_y  = sub_pos(w_item_reg.cell_y, w_item_reg.level, iy_reg);
        cand.sub_z  = sub_pos(w_item_reg.cell_z, w_item_reg.level, iz_reg);
    end

    // walker: x fastest, then y, then z
    always_comb
    begin
        w_active_next = w_active_reg;
        w_item_next   = w_item_reg;
        ix_next       = ix_reg;
        iy_next       = iy_reg;
        iz_next       = iz_reg;
        if (load)
        begin
            w_active_next = 1'b1;
            w_item_next   = q_data;
            ix_next       = '0;
            iy_next       = '0;
            iz_next       = '0;
        end
        else if (c_take && w_last)
        begin
            w_active_next = 1'b0;
        end
        else if (c_take)
        begin
            ix_next = last_x ? '0 : ix_reg + 1'b1;
            if (last_x)
            begin
                iy_next = last_y ? '0 : iy_reg + 1'b1;
                if (last_y)
                begin
                    iz_next = iz_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        c_valid_next  = c_valid_reg;
        c_inside_next = c_inside_reg;
        c_end_next    = c_end_reg;
        c_seed_next   = c_seed_reg;
        if (c_take)
        begin
            c_valid_next  = 1'b1;
            c_inside_next = cand_inside;
            c_end_next    = w_last;
            c_seed_next   = cand;
        end
        else if (c_valid_reg && adv)
        begin
            c_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        p_valid_next  = p_valid_reg;
        p_closed_next = p_closed_reg;
        p_seed_next   = p_seed_reg;
        if (adv)
        begin
            if (c_valid_reg && c_inside_reg)
            begin
                p_valid_next  = 1'b1;
                p_closed_next = c_end_reg;
                p_seed_next   = c_seed_reg;
            end
            else if (emit)
            begin
                p_valid_next = 1'b0;
            end
            else if (c_valid_reg && c_end_reg && p_valid_reg)
            begin
                p_closed_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        o_valid_next = o_valid_reg;
        o_last_next  = o_last_reg;
        o_seed_next  = o_seed_reg;
        o_num_next   = o_num_reg;
        count_next   = count_reg;
        if (emit && adv)
        begin
            o_valid_next = 1'b1;
            o_last_next  = p_closed_reg;
            o_seed_next  = p_seed_reg;
            o_num_next   = count_reg;
            count_next   = count_reg + 1'b1;
        end
        else if (m_tready)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_active_reg <= 1'b0;
            c_valid_reg  <= 1'b0;
            p_valid_reg  <= 1'b0;
            p_closed_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            w_active_reg <= w_active_next;
            c_valid_reg  <= c_valid_next;
            p_valid_reg  <= p_valid_next;
            p_closed_reg <= p_closed_next;
            o_valid_reg  <= o_valid_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_item_reg   <= w_item_next;
        ix_reg       <= ix_next;
        iy_reg       <= iy_next;
        iz_reg       <= iz_next;
        c_inside_reg <= c_inside_next;
        c_end_reg    <= c_end_next;
        c_seed_reg   <= c_seed_next;
        p_seed_reg   <= p_seed_next;
        o_last_reg   <= o_last_next;
        o_seed_reg   <= o_seed_next;
        o_num_reg    <= o_num_next;
    end

    assign m_tvalid = o_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, o_num_reg, o_seed_reg};

    assign stat.walk_active = w_active_reg;
    assign stat.cand_valid  = c_valid_reg;
    assign stat.pend_valid  = p_valid_reg;
    assign stat.pend_closed = p_closed_reg;

endmodule
